[rtl/rrsd_pkg.sv]
package rrsd_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;
  localparam logic [1:0] KIND_SLICE  = 2'd3;

  // configuration register indexes
  localparam logic REG_QUANTUM   = 1'b0;
  localparam logic REG_JOB_COUNT = 1'b1;

  localparam int TIME_W  = 32;
  localparam int SLICE_W = 16;
  localparam int JOBS_W  = 6;
  localparam int SLOT_W  = 5;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd500;
  localparam logic [JOBS_W-1:0]  JOBS_RESET  = 6'd1;
  localparam logic [TIME_W-1:0]  TIME_MAX    = 32'hFFFF_FFFF;
  localparam logic [JOBS_W-1:0]  COUNT_MAX   = 6'd63;

  // one table slot as stored in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0] ready_at;
    logic [TIME_W-1:0] remaining;
  } slot_entry_t;

endpackage

[rtl/rrsd_ram.sv]
module rrsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/round_robin_slot_dispatcher.sv]
// channel  direction  handshake                fields
// in       input      in_valid / in_ready      kind, slot_index, ready_at, run_length
// out      output     out_valid / out_ready    granted, granted_slot, grant_amount,
//                                              now_time, all_done
// cfg      input      cfg_write (no wait)      cfg_index, cfg_data
//
// load, finish and slice-end items produce their result in the cycle after acceptance.
// a tick scans one slot per cycle through the slot memory read port over the n slots in use
// (job_count capped at MAX_SLOTS) and stops at the first eligible slot, which it grants;
// a tick while dispatch is disabled or no slots are in use posts its result without a scan.
// in_ready is low during a scan and a grant and while a result waits with out_ready low.
// rst is synchronous; slot memory contents are not cleared and must be loaded.
module round_robin_slot_dispatcher #(
  parameter int MAX_SLOTS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   kind,
  input  logic [rrsd_pkg::SLOT_W-1:0]  slot_index,
  input  logic [rrsd_pkg::TIME_W-1:0]  ready_at,
  input  logic [rrsd_pkg::TIME_W-1:0]  run_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         granted,
  output logic [rrsd_pkg::SLOT_W-1:0]  granted_slot,
  output logic [rrsd_pkg::SLICE_W-1:0] grant_amount,
  output logic [rrsd_pkg::TIME_W-1:0]  now_time,
  output logic                         all_done,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [rrsd_pkg::SLICE_W-1:0] cfg_data
);

  import rrsd_pkg::*;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = (CNT_W > JOBS_W) ? CNT_W : JOBS_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_GRANT} state_t;

  state_t              state;
  logic [SLICE_W-1:0]  quantum;
  logic [JOBS_W-1:0]   job_count;
  logic [IDX_W-1:0]    scan_pointer;
  logic [TIME_W-1:0]   current_time;
  logic                dispatch_enabled;
  logic [JOBS_W-1:0]   finished_count;
  logic [IDX_W-1:0]    scan_slot;
  logic [CNT_W-1:0]    scan_cnt;
  slot_entry_t         hit_entry;

  logic                in_accept;
  logic [CNT_W-1:0]    n_use;
  logic [IDX_W-1:0]    start_slot;
  logic [CNT_W-1:0]    slot_inc;
  logic [IDX_W-1:0]    slot_wrap;
  logic                eligible;
  logic                load_ok;
  logic [SLICE_W-1:0]  gamt;
  logic [JOBS_W-1:0]   finished_count_next;
  logic [TIME_W-1:0]   current_time_next;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  slot_entry_t         ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  slot_entry_t         ram_rdata;

  assign in_accept = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);

  always_comb begin
    if (CMP_W'(job_count) > CMP_W'(MAX_SLOTS)) begin
      n_use = CNT_W'(MAX_SLOTS);
    end else begin
      n_use = CNT_W'(job_count);
    end
    start_slot = (CNT_W'(scan_pointer) >= n_use) ? '0 : scan_pointer;
    slot_inc   = CNT_W'(scan_slot) + CNT_W'(1);
    slot_wrap  = (slot_inc < n_use) ? IDX_W'(slot_inc) : '0;
    eligible   = (ram_rdata.remaining != '0) && (ram_rdata.ready_at <= current_time);
    load_ok    = (32'(slot_index) < 32'(MAX_SLOTS));
    if (hit_entry.remaining > TIME_W'(quantum)) begin
      gamt = quantum;
    end else begin
      gamt = hit_entry.remaining[SLICE_W-1:0];
    end
    finished_count_next = (finished_count != COUNT_MAX) ? finished_count + 1'b1
                                                        : finished_count;
    current_time_next   = (current_time != TIME_MAX) ? current_time + 1'b1
                                                     : current_time;
  end

  // memory ports: loads and grant write-back share the write port
  always_comb begin
    ram_raddr = (state == ST_IDLE) ? start_slot : slot_wrap;
    if (state == ST_GRANT) begin
      ram_we              = 1'b1;
      ram_waddr           = scan_slot;
      ram_wdata.ready_at  = hit_entry.ready_at;
      ram_wdata.remaining = hit_entry.remaining - TIME_W'(gamt);
    end else begin
      ram_we              = in_accept && (kind == KIND_LOAD) && load_ok;
      ram_waddr           = IDX_W'(slot_index);
      ram_wdata.ready_at  = ready_at;
      ram_wdata.remaining = run_length;
    end
  end

  rrsd_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      quantum          <= SLICE_RESET;
      job_count        <= JOBS_RESET;
      scan_pointer     <= '0;
      current_time     <= '0;
      dispatch_enabled <= 1'b1;
      finished_count   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_QUANTUM:   quantum   <= cfg_data;
          REG_JOB_COUNT: job_count <= cfg_data[JOBS_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            granted      <= 1'b0;
            granted_slot <= '0;
            grant_amount <= '0;
            now_time     <= current_time;
            all_done     <= (kind == KIND_FINISH) ? (finished_count_next == job_count)
                                                  : (finished_count == job_count);
            unique case (kind)
              KIND_LOAD: begin
                out_valid <= 1'b1;
              end
              KIND_TICK: begin
                if (dispatch_enabled && (n_use != '0)) begin
                  scan_slot <= start_slot;
                  scan_cnt  <= '0;
                  out_valid <= 1'b0;
                  state     <= ST_SCAN;
                end else begin
                  current_time <= current_time_next;
                  out_valid    <= 1'b1;
                end
              end
              KIND_FINISH: begin
                finished_count   <= finished_count_next;
                dispatch_enabled <= 1'b1;
                out_valid        <= 1'b1;
              end
              default: begin
                dispatch_enabled <= 1'b1;
                out_valid        <= 1'b1;
              end
            endcase
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end

        // ram_rdata holds the entry of scan_slot
        ST_SCAN: begin
          if (eligible) begin
            hit_entry <= ram_rdata;
            state     <= ST_GRANT;
          end else if (scan_cnt + 1'b1 == n_use) begin
            current_time <= current_time_next;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            scan_cnt  <= scan_cnt + 1'b1;
            scan_slot <= slot_wrap;
          end
        end

        ST_GRANT: begin
          granted          <= 1'b1;
          granted_slot     <= SLOT_W'(scan_slot);
          grant_amount     <= gamt;
          scan_pointer     <= slot_wrap;
          dispatch_enabled <= 1'b0;
          current_time     <= current_time_next;
          out_valid        <= 1'b1;
          state            <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_cnt < n_use))
    else $error("scan ran past the slots in use");

  a_grant_disables: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GRANT) |=> (!dispatch_enabled && out_valid && granted))
    else $error("grant did not disable dispatch or post a result");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> ((grant_amount == '0) && (granted_slot == '0)))
    else $error("non-grant result carries a slot or amount");

  a_grant_bounded: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |-> (grant_amount <= quantum))
    else $error("grant exceeds time slice");

  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (current_time >= $past(current_time)))
    else $error("current time went backward");

endmodule
